[hw/rtl/sef_pkg.sv]
package sef_pkg;

    // Field widths
    localparam int KIND_W     = 2;
    localparam int SRC_W      = 32;
    localparam int ARG_W      = 64;
    localparam int OSEQ_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int FILL_W     = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Stream packing
    localparam int IN_DATA_W  = 160;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 200;
    localparam int OUT_USER_W = 5;

    // Request types
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SEQ_EXHST = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [FILL_W-1:0]     CAP_RESET       = 5'd16;
    localparam logic [CFG_DATA_W-1:0] FIRST_SEQ_RESET = 32'd1;
    localparam logic [CFG_DATA_W-1:0] SEQ_LIMIT_RESET = 32'hFFFF_FFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;   // capture the input beat
        logic exec;    // evaluate request, update queue state
        logic load;    // move result into output register
    } sef_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;  // output register holds a beat not yet taken
    } sef_stat_t;

endpackage

[hw/rtl/sequenced_event_fifo.sv]
// Sequence: a request beat is captured, then executed (slot write or registered
// slot read), then loaded into the output register when that register is free or being read.
// A new request beat is accepted only after the previous result has been loaded.
// Reset: rst_n is asynchronous, active low; the queue is empty, capacity 16,
// first sequence 1, sequence limit all ones. Slot contents are not cleared.
module sequenced_event_fifo
    import sef_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int SEQ_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // tdata: src_id[31:0], arg_first[95:32], arg_second[159:96]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: req_type[0], evt_kind[2:1]
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: out_source[31:0], out_sequence[63:32], out_arg_first[127:64],
    //        out_arg_second[191:128], fill_level[196:192], is_empty[197],
    //        is_full[198], zero[199]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tuser: status[2:0], out_kind[4:3]
    output logic [OUT_USER_W-1:0] m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sef_cmd_t  cmd;
    sef_stat_t stat;

    sef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sef_datapath #(
        .DEPTH (DEPTH),
        .SEQ_W (SEQ_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[hw/rtl/sef_ctrl.sv]
module sef_ctrl
    import sef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  sef_stat_t stat,
    output sef_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencing: take beat, execute, hand result to output register
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/sef_datapath.sv]
module sef_datapath
    import sef_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int SEQ_W = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sef_cmd_t              cmd,
    output sef_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = ((IDX_W > FILL_W) ? IDX_W : FILL_W) + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

    // Configuration registers
    logic [FILL_W-1:0]     cap_reg;
    logic [CFG_DATA_W-1:0] first_seq_reg;
    logic [CFG_DATA_W-1:0] seq_limit_reg;

    // Queue state
    logic [IDX_W-1:0]  head_reg,  head_next;
    logic [FILL_W-1:0] count_reg, count_next;
    logic [SEQ_W-1:0]  seq_reg,   seq_next;

    // Captured request
    logic              req_type_reg;
    logic [KIND_W-1:0] req_kind_reg;
    logic [SRC_W-1:0]  req_src_reg;
    logic [ARG_W-1:0]  req_a0_reg;
    logic [ARG_W-1:0]  req_a1_reg;

    // Result of execution
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [SEQ_W-1:0]    pend_seq_reg;

    // Slot storage
    logic [KIND_W-1:0] mem_kind [DEPTH];
    logic [SRC_W-1:0]  mem_src  [DEPTH];
    logic [SEQ_W-1:0]  mem_seq  [DEPTH];
    logic [ARG_W-1:0]  mem_a0   [DEPTH];
    logic [ARG_W-1:0]  mem_a1   [DEPTH];

    logic [KIND_W-1:0] rd_kind_reg;
    logic [SRC_W-1:0]  rd_src_reg;
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic [ARG_W-1:0]  rd_a0_reg;
    logic [ARG_W-1:0]  rd_a1_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_USER_W-1:0] out_user_reg;

    logic [SUM_W-1:0] cap_s;
    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] pos_wrap;
    logic [SUM_W-1:0] head_inc;
    logic [IDX_W-1:0] wr_idx;
    logic             is_full_now;
    logic             push_ok;
    logic             pop_ok;

    // Effective capacity: zero counts as one, clamp at DEPTH
    always_comb
    begin
        cap_s = SUM_W'(cap_reg);
        priority if (cap_reg == '0)
        begin
            cap_s = SUM_W'(1);
        end
        else if (cap_s > DEPTH_S)
        begin
            cap_s = DEPTH_S;
        end
        else
        begin
            cap_s = SUM_W'(cap_reg);
        end
    end

    // Write slot: head plus count, wrapped once at capacity
    always_comb
    begin
        pos_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
        pos_wrap = (pos_sum >= cap_s) ? (pos_sum - cap_s) : pos_sum;
        wr_idx   = (pos_wrap >= DEPTH_S) ? '0 : pos_wrap[IDX_W-1:0];
        head_inc = SUM_W'(head_reg) + SUM_W'(1);
    end

    assign is_full_now = (SUM_W'(count_reg) >= cap_s);

    // Request decision and next queue state
    always_comb
    begin
        pend_status_next = ST_OK;
        push_ok          = 1'b0;
        pop_ok           = 1'b0;
        head_next        = head_reg;
        count_next       = count_reg;
        seq_next         = seq_reg;
        if (req_type_reg == REQ_PUSH)
        begin
            priority if (req_kind_reg == KIND_NONE)
            begin
                pend_status_next = ST_BAD_KIND;
            end
            else if (is_full_now)
            begin
                pend_status_next = ST_FULL;
            end
            else if (seq_reg == SEQ_W'(seq_limit_reg))
            begin
                pend_status_next = ST_SEQ_EXHST;
            end
            else
            begin
                push_ok    = 1'b1;
                count_next = count_reg + FILL_W'(1);
                seq_next   = seq_reg + SEQ_W'(1);
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                pend_status_next = ST_EMPTY;
            end
            else
            begin
                pop_ok     = 1'b1;
                count_next = count_reg - FILL_W'(1);
                head_next  = (head_inc >= cap_s) ? '0 : head_inc[IDX_W-1:0];
            end
        end
    end

    // Configuration and queue state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            first_seq_reg <= FIRST_SEQ_RESET;
            seq_limit_reg <= SEQ_LIMIT_RESET;
            head_reg      <= '0;
            count_reg     <= '0;
            seq_reg       <= SEQ_W'(FIRST_SEQ_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:
                begin
                    cap_reg   <= cfg_data[FILL_W-1:0];
                    head_reg  <= '0;
                    count_reg <= '0;
                    seq_reg   <= SEQ_W'(first_seq_reg);
                end
                CFG_FIRST_SEQ:
                begin
                    first_seq_reg <= cfg_data;
                    seq_reg       <= SEQ_W'(cfg_data);
                end
                CFG_SEQ_LIMIT:
                begin
                    seq_limit_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
        end
    end

    // Input beat capture and execution results
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_type_reg <= s_tuser[0];
            req_kind_reg <= s_tuser[2:1];
            req_src_reg  <= s_tdata[31:0];
            req_a0_reg   <= s_tdata[95:32];
            req_a1_reg   <= s_tdata[159:96];
        end
        if (cmd.exec)
        begin
            pend_status_reg <= pend_status_next;
            pend_seq_reg    <= seq_reg;
        end
    end

    // Slot memory: one write port, one registered read port at head
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
        begin
            mem_kind[wr_idx] <= req_kind_reg;
            mem_src[wr_idx]  <= req_src_reg;
            mem_seq[wr_idx]  <= seq_reg;
            mem_a0[wr_idx]   <= req_a0_reg;
            mem_a1[wr_idx]   <= req_a1_reg;
        end
        if (cmd.exec && pop_ok)
        begin
            rd_kind_reg <= mem_kind[head_reg];
            rd_src_reg  <= mem_src[head_reg];
            rd_seq_reg  <= mem_seq[head_reg];
            rd_a0_reg   <= mem_a0[head_reg];
            rd_a1_reg   <= mem_a1[head_reg];
        end
    end

    // Result assembly
    logic [KIND_W-1:0] res_kind;
    logic [SRC_W-1:0]  res_src;
    logic [SEQ_W-1:0]  res_seq;
    logic [ARG_W-1:0]  res_a0;
    logic [ARG_W-1:0]  res_a1;
    logic              res_empty;
    logic              res_full;

    always_comb
    begin
        res_kind = '0;
        res_src  = '0;
        res_seq  = '0;
        res_a0   = '0;
        res_a1   = '0;
        if (pend_status_reg == ST_OK)
        begin
            if (req_type_reg == REQ_POP)
            begin
                res_kind = rd_kind_reg;
                res_src  = rd_src_reg;
                res_seq  = rd_seq_reg;
                res_a0   = rd_a0_reg;
                res_a1   = rd_a1_reg;
            end
            else
            begin
                res_kind = req_kind_reg;
                res_src  = req_src_reg;
                res_seq  = pend_seq_reg;
                res_a0   = req_a0_reg;
                res_a1   = req_a1_reg;
            end
        end
        res_empty = (count_reg == '0);
        res_full  = (SUM_W'(count_reg) == cap_s);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {1'b0, res_full, res_empty, count_reg,
                             res_a1, res_a0, OSEQ_W'(res_seq), res_src};
            out_user_reg <= {res_kind, pend_status_reg};
        end
    end

    assign stat.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign m_tuser       = out_user_reg;

endmodule
